@@ rtl/rational_arith_unit_macros.svh @@
// Assertion macros shared by the rational arithmetic unit.
`ifndef RATIONAL_ARITH_UNIT_MACROS_SVH
`define RATIONAL_ARITH_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define RAU_ASSERT_IMPLY(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during rst.
`define RAU_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

@@ rtl/rau_pkg.sv @@
// Types shared by the rational arithmetic unit modules.
package rau_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef struct packed {
    logic neg;
    logic dz;
  } res_tag_t;

endpackage

@@ rtl/rau_gcd.sv @@
// Pipelined binary greatest common divisor, one step per register stage.
module rau_gcd import rau_pkg::*; #(
  parameter int MW = 32,
  parameter int KW = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          in_valid,
  input  logic [MW-1:0] in_mn,
  input  logic [MW-1:0] in_md,
  input  res_tag_t      in_tag,
  output logic          out_valid,
  output logic [MW-1:0] out_mn,
  output logic [MW-1:0] out_md,
  output logic [MW-1:0] out_g,
  output res_tag_t      out_tag
);

  localparam int NG = 2 * MW;

  logic          v   [NG+1];
  logic [MW-1:0] a   [NG+1];
  logic [MW-1:0] b   [NG+1];
  logic [KW-1:0] k   [NG+1];
  logic [MW-1:0] mn  [NG+1];
  logic [MW-1:0] md  [NG+1];
  res_tag_t      tag [NG+1];

  assign v[0]   = in_valid;
  assign a[0]   = in_mn;
  assign b[0]   = in_md;
  assign k[0]   = '0;
  assign mn[0]  = in_mn;
  assign md[0]  = in_md;
  assign tag[0] = in_tag;

  for (genvar j = 0; j < NG; j++) begin : g_step
    logic [MW-1:0] a_next, b_next;
    logic [KW-1:0] k_next;

    always_comb begin
      a_next = a[j];
      b_next = b[j];
      k_next = k[j];
      priority if (a[j] == '0 || b[j] == '0) begin
        a_next = a[j];
      end else if (!a[j][0] && !b[j][0]) begin
        a_next = a[j] >> 1;
        b_next = b[j] >> 1;
        k_next = k[j] + KW'(1);
      end else if (!a[j][0]) begin
        a_next = a[j] >> 1;
      end else if (!b[j][0]) begin
        b_next = b[j] >> 1;
      end else if (a[j] >= b[j]) begin
        a_next = (a[j] - b[j]) >> 1;
      end else begin
        b_next = (b[j] - a[j]) >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j+1] <= 1'b0;
      end else if (adv) begin
        v[j+1] <= v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        a[j+1]   <= a_next;
        b[j+1]   <= b_next;
        k[j+1]   <= k_next;
        mn[j+1]  <= mn[j];
        md[j+1]  <= md[j];
        tag[j+1] <= tag[j];
      end
    end
  end

  assign out_valid = v[NG];
  assign out_mn    = mn[NG];
  assign out_md    = md[NG];
  assign out_g     = (a[NG] | b[NG]) << k[NG];
  assign out_tag   = tag[NG];

endmodule

@@ rtl/rau_div.sv @@
// Pipelined restoring division of both magnitudes by the common divisor.
module rau_div import rau_pkg::*; #(
  parameter int MW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          in_valid,
  input  logic [MW-1:0] in_mn,
  input  logic [MW-1:0] in_md,
  input  logic [MW-1:0] in_g,
  input  res_tag_t      in_tag,
  output logic          out_valid,
  output logic [MW-1:0] out_qn,
  output logic [MW-1:0] out_qd,
  output res_tag_t      out_tag
);

  logic          v   [MW+1];
  logic [MW-1:0] g   [MW+1];
  logic [MW-1:0] dn  [MW+1];
  logic [MW-1:0] dd  [MW+1];
  logic [MW-1:0] rn  [MW+1];
  logic [MW-1:0] rd  [MW+1];
  res_tag_t      tag [MW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (adv) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g[0]   <= in_g;
      dn[0]  <= in_mn;
      dd[0]  <= in_md;
      rn[0]  <= '0;
      rd[0]  <= '0;
      tag[0] <= in_tag;
    end
  end

  for (genvar j = 0; j < MW; j++) begin : g_step
    logic [MW:0]   tn, td;
    logic [MW-1:0] rn_next, rd_next;
    logic          qn_bit, qd_bit;

    always_comb begin
      tn = {rn[j], dn[j][MW-1]};
      td = {rd[j], dd[j][MW-1]};
      qn_bit = (tn >= {1'b0, g[j]});
      qd_bit = (td >= {1'b0, g[j]});
      rn_next = qn_bit ? MW'(tn - {1'b0, g[j]}) : tn[MW-1:0];
      rd_next = qd_bit ? MW'(td - {1'b0, g[j]}) : td[MW-1:0];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j+1] <= 1'b0;
      end else if (adv) begin
        v[j+1] <= v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        g[j+1]   <= g[j];
        dn[j+1]  <= {dn[j][MW-2:0], qn_bit};
        dd[j+1]  <= {dd[j][MW-2:0], qd_bit};
        rn[j+1]  <= rn_next;
        rd[j+1]  <= rd_next;
        tag[j+1] <= tag[j];
      end
    end
  end

  assign out_valid = v[MW];
  assign out_qn    = dn[MW];
  assign out_qd    = dd[MW];
  assign out_tag   = tag[MW];

endmodule

@@ rtl/rational_arith_unit.sv @@
// Rational arithmetic unit: adds, subtracts, multiplies or divides two signed
// fractions and returns the result in lowest terms with a positive denominator.
// The block is a pipeline that takes one word per cycle while m_tvalid is low
// or m_tready is high, and stalls as a whole otherwise; a word passes the
// binary GCD with one step per stage (4 * OPERAND_WIDTH stages) and then the
// restoring divider with one quotient bit per stage (2 * OPERAND_WIDTH stages).
// A zero denominator raises div_zero and gives 0/1, and a zero numerator
// gives 0/1.
`include "rational_arith_unit_macros.svh"

module rational_arith_unit import rau_pkg::*; #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // Fields from bit 0: num_a, den_a, num_b, den_b, zero fill.
  input  logic [((4*OPERAND_WIDTH+7)/8)*8-1:0]   s_tdata,
  // Fields from bit 0: operation.
  input  logic [1:0]                             s_tuser,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // Fields from bit 0: res_num, res_den, zero fill.
  output logic [((4*OPERAND_WIDTH+7)/8)*8-1:0]   m_tdata,
  // Fields from bit 0: div_zero.
  output logic                                   m_tuser
);

  localparam int W  = OPERAND_WIDTH;
  localparam int MW = 2 * W;
  localparam int KW = $clog2(MW + 1);
  localparam int DW = ((4 * W + 7) / 8) * 8;

  logic adv;

  logic                 v1, v2, v3, v4;
  op_t                  op1, op2;
  logic signed [W-1:0]  na1, da1, nb1, db1;
  logic signed [MW-1:0] p1, p2, pd;
  logic signed [MW:0]   rn3;
  logic signed [MW-1:0] rd3;
  logic [MW-1:0]        mn4, md4;
  res_tag_t             tag4;

  logic signed [MW-1:0] p1_next, p2_next, pd_next;
  logic signed [MW:0]   rn_next, rn_abs;
  logic signed [MW-1:0] rd_abs;
  logic [MW-1:0]        mn_next, md_next;
  res_tag_t             tag_next;

  logic                 gv;
  logic [MW-1:0]        gmn, gmd, gg;
  res_tag_t             gtag;
  logic                 dv;
  logic [MW-1:0]        qn, qd;
  res_tag_t             dtag;

  logic [MW:0]          out_num, num_next;
  logic [MW-2:0]        out_den;
  logic                 out_dz;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  always_comb begin
    p2_next = '0;
    unique case (op1)
      OP_ADD, OP_SUB: begin
        p1_next = na1 * db1;
        p2_next = nb1 * da1;
        pd_next = da1 * db1;
      end
      OP_MUL: begin
        p1_next = na1 * nb1;
        pd_next = da1 * db1;
      end
      OP_DIV: begin
        p1_next = na1 * db1;
        pd_next = da1 * nb1;
      end
      default: begin
        p1_next = '0;
        pd_next = '0;
      end
    endcase
  end

  always_comb begin
    if (op2 == OP_SUB) begin
      rn_next = p1 - p2;
    end else begin
      rn_next = p1 + p2;
    end
  end

  always_comb begin
    rn_abs = rn3[MW] ? -rn3 : rn3;
    rd_abs = rd3[MW-1] ? -rd3 : rd3;
    tag_next.dz = (rd3 == '0);
    if (rd3 == '0 || rn3 == '0) begin
      mn_next      = '0;
      md_next      = MW'(1);
      tag_next.neg = 1'b0;
    end else begin
      mn_next      = rn_abs[MW-1:0];
      md_next      = rd_abs;
      tag_next.neg = rn3[MW] ^ rd3[MW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op1  <= op_t'(s_tuser);
      na1  <= s_tdata[W-1:0];
      da1  <= s_tdata[2*W-1:W];
      nb1  <= s_tdata[3*W-1:2*W];
      db1  <= s_tdata[4*W-1:3*W];
      op2  <= op1;
      p1   <= p1_next;
      p2   <= p2_next;
      pd   <= pd_next;
      rn3  <= rn_next;
      rd3  <= pd;
      mn4  <= mn_next;
      md4  <= md_next;
      tag4 <= tag_next;
    end
  end

  rau_gcd #(.MW(MW), .KW(KW)) u_gcd (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (v4),
    .in_mn     (mn4),
    .in_md     (md4),
    .in_tag    (tag4),
    .out_valid (gv),
    .out_mn    (gmn),
    .out_md    (gmd),
    .out_g     (gg),
    .out_tag   (gtag)
  );

  rau_div #(.MW(MW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (gv),
    .in_mn     (gmn),
    .in_md     (gmd),
    .in_g      (gg),
    .in_tag    (gtag),
    .out_valid (dv),
    .out_qn    (qn),
    .out_qd    (qd),
    .out_tag   (dtag)
  );

  always_comb begin
    if (dtag.neg) begin
      num_next = -{1'b0, qn};
    end else begin
      num_next = {1'b0, qn};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= dv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_num <= num_next;
      out_den <= qd[MW-2:0];
      out_dz  <= dtag.dz;
    end
  end

  assign m_tdata = DW'({out_den, out_num});
  assign m_tuser = out_dz;

  `RAU_ASSERT_IMPLY(a_dz_gives_zero, m_tvalid && out_dz, out_num == '0 && out_den == (MW-1)'(1), "division by zero did not give 0/1")
  `RAU_ASSERT_IMPLY(a_den_nonzero, m_tvalid, out_den != '0, "result denominator is zero")
  `RAU_ASSERT_IMPLY(a_zero_reduced, m_tvalid && out_num == '0, out_den == (MW-1)'(1), "zero result not reduced to 0/1")
  `RAU_ASSERT_NEXT(a_front_moves, v1 && adv, v2, "word lost between the first two stages")

endmodule

@@ tb/tb_top.sv @@
// Testbench for the rational arithmetic unit: directed table, then random words.
module tb_top;
  import rau_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = 16;
  localparam int DW = ((4*W+7)/8)*8;
  localparam int LATENCY = 6*W + 6;

  typedef struct packed {
    logic [32:0] num;
    logic [30:0] den;
    logic        dz;
  } frac_t;

  typedef struct {
    op_t         op;
    logic [15:0] na, da, nb, db;
    logic        known;
    frac_t       res;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [DW-1:0] s_tdata = '0;
  logic [1:0] s_tuser = OP_ADD;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [DW-1:0] m_tdata;
  logic m_tuser;

  frac_t quotients[$];
  int errors = 0;
  int hold_off = 0;
  int got = 0;
  bit held = 1'b0;
  bit drained = 1'b0;
  bit done = 1'b0;
  row_t rows[$];

  always #5 clk = ~clk;

  rational_arith_unit #(.OPERAND_WIDTH(W)) dut (.*);

  function automatic frac_t reduce_frac(op_t op, logic signed [15:0] na,
      logic signed [15:0] da, logic signed [15:0] nb, logic signed [15:0] db);
    logic signed [63:0] rn, rd;
    logic [63:0] mn, md, p, q, r;
    logic neg;
    frac_t f;
    case (op)
      OP_ADD: begin rn = na*db + nb*da; rd = da*db; end
      OP_SUB: begin rn = na*db - nb*da; rd = da*db; end
      OP_MUL: begin rn = na*nb; rd = da*db; end
      default: begin rn = na*db; rd = da*nb; end
    endcase
    f.num = '0; f.den = 31'd1; f.dz = 1'b0;
    if (rd == 0) begin
      f.dz = 1'b1;
    end else if (rn != 0) begin
      neg = rn[63] ^ rd[63];
      mn = rn[63] ? -rn : rn;
      md = rd[63] ? -rd : rd;
      p = mn; q = md;
      while (q != 0) begin r = p % q; p = q; q = r; end
      mn = mn / p; md = md / p;
      f.num = neg ? 33'(-mn) : 33'(mn);
      f.den = md[30:0];
    end
    return f;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  function automatic row_t mk(op_t op, logic [15:0] na, logic [15:0] da,
      logic [15:0] nb, logic [15:0] db, logic known = 1'b0, frac_t res = '0);
    row_t t;
    t.op = op; t.na = na; t.da = da; t.nb = nb; t.db = db;
    t.known = known; t.res = res;
    return t;
  endfunction

  task automatic send_word(row_t t);
    s_tvalid <= 1'b1;
    s_tuser <= t.op;
    s_tdata <= {t.db, t.nb, t.da, t.na};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    quotients.push_back(t.known ? t.res :
      reduce_frac(t.op, t.na, t.da, t.nb, t.db));
  endtask

  function automatic logic [15:0] rnd_operand();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 2)) - 16'd1;
      3: return 16'($urandom_range(0, 16)) - 16'd8;
      default: return 16'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_tready <= 1'b0;
    end else if (!held && got >= 300) begin
      held <= 1'b1;
      hold_off <= 400;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 7) < 5) || ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk) begin
    frac_t want;
    if (!rst && m_tvalid && m_tready) begin
      got <= got + 1;
      if (quotients.size() == 0) begin
        report_mismatch("unexpected word", m_tdata, 64'd0);
      end else begin
        want = quotients.pop_front();
        if (m_tdata[32:0] !== want.num) report_mismatch("res_num", m_tdata[32:0], want.num);
        if (m_tdata[63:33] !== want.den) report_mismatch("res_den", m_tdata[63:33], want.den);
        if (m_tuser !== want.dz) report_mismatch("div_zero", m_tuser, want.dz);
      end
    end
  end

  initial begin
    int burst;
    rows.push_back(mk(OP_ADD, 16'd0, 16'd1, 16'd0, 16'd1, 1'b1, '{33'd0, 31'd1, 1'b0}));
    rows.push_back(mk(OP_ADD, 16'd1, 16'd0, 16'd1, 16'd1, 1'b1, '{33'd0, 31'd1, 1'b1}));
    rows.push_back(mk(OP_MUL, 16'd3, 16'd5, 16'd2, 16'd0, 1'b1, '{33'd0, 31'd1, 1'b1}));
    rows.push_back(mk(OP_DIV, 16'd3, 16'd5, 16'd0, 16'd7, 1'b1, '{33'd0, 31'd1, 1'b1}));
    rows.push_back(mk(OP_MUL, 16'd4, 16'd1, 16'd1, 16'd2, 1'b1, '{33'd2, 31'd1, 1'b0}));
    rows.push_back(mk(OP_MUL, 16'd0, 16'd64, 16'd5, 16'd1, 1'b1, '{33'd0, 31'd1, 1'b0}));
    rows.push_back(mk(OP_SUB, 16'd1, 16'd2, 16'd1, 16'd2, 1'b1, '{33'd0, 31'd1, 1'b0}));
    rows.push_back(mk(OP_ADD, 16'h8000, 16'd1, 16'h8000, 16'd1));
    rows.push_back(mk(OP_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000));
    rows.push_back(mk(OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
    rows.push_back(mk(OP_MUL, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff));
    rows.push_back(mk(OP_DIV, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000));
    rows.push_back(mk(OP_DIV, 16'h7fff, 16'hffff, 16'hffff, 16'h8000));
    rows.push_back(mk(OP_ADD, 16'd1, 16'hfffd, 16'd1, 16'hfffa));
    rows.push_back(mk(OP_SUB, 16'hffff, 16'h7fff, 16'h7fff, 16'h7ffe));
    rows.push_back(mk(OP_DIV, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    rows.push_back(mk(OP_ADD, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff));

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    foreach (rows[i]) send_word(rows[i]);
    s_tvalid <= 1'b0;

    for (int n = 0; n < 1600; ) begin
      if (n >= 900 && !drained) begin
        drained = 1'b1;
        s_tvalid <= 1'b0;
        while (quotients.size() != 0) @(posedge clk);
      end
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst; k++) begin
        send_word(mk(op_t'($urandom_range(0, 3)), rnd_operand(), rnd_operand(),
          rnd_operand(), rnd_operand()));
        n++;
      end
      if ($urandom_range(0, 2) != 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
    s_tvalid <= 1'b0;
    while (quotients.size() != 0) @(posedge clk);
    repeat (2*LATENCY) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/rau_pkg.sv
rtl/rau_gcd.sv
rtl/rau_div.sv
rtl/rational_arith_unit.sv
tb/tb_top.sv
